// ----- src/sliq_pkg.sv -----
// Shared types and constants for the streaming lock-in I/Q detector.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package sliq_pkg;

  localparam int unsigned CordicStepsDef = 31;
  localparam int unsigned CordicStepsMax = 31;

  localparam logic [1:0] RegFilterGain   = 2'd0;
  localparam logic [1:0] RegMinAmplitude = 2'd1;
  localparam logic [1:0] RegSettlingCnt  = 2'd2;

  localparam logic [15:0] GainReset   = 16'd1024;
  localparam logic [15:0] GainUnity   = 16'd32768;
  localparam logic [31:0] SettleReset = 32'd1;

  localparam logic signed [19:0] PhaseFullMd    = 20'sd360000;
  localparam logic signed [18:0] PhaseQuarterMd = 19'sd90000;

  localparam logic [31:0] AtanTable [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic ld_in;
    logic clr;
    logic prod;
    logic tgt;
    logic fmul;
    logic fupd;
    logic sat;
    logic sq;
    logic sum;
    logic amul;
    logic arnd;
    logic out_ld;
  } sliq_cmd_t;

  typedef struct packed {
    logic sqrt_busy;
    logic cordic_busy;
  } sliq_sts_t;

endpackage

// ----- src/sliq_ctrl.sv -----
// Sequencing controller for the lock-in detector: input/output handshakes
// and step commands to sliq_dp. Depends on sliq_pkg.
`timescale 1ns / 1ps
module sliq_ctrl
  import sliq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_action_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  sliq_sts_t sts_i,
  output sliq_cmd_t cmd_o
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StProd = 4'd1;
  localparam logic [3:0] StTgt  = 4'd2;
  localparam logic [3:0] StFmul = 4'd3;
  localparam logic [3:0] StFupd = 4'd4;
  localparam logic [3:0] StSat  = 4'd5;
  localparam logic [3:0] StSq   = 4'd6;
  localparam logic [3:0] StSum  = 4'd7;
  localparam logic [3:0] StIter = 4'd8;
  localparam logic [3:0] StAmul = 4'd9;
  localparam logic [3:0] StArnd = 4'd10;
  localparam logic [3:0] StDone = 4'd11;

  logic [3:0] state_q, state_d;
  logic       ovld_q, ovld_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovld_q;

  always_comb begin
    state_d = state_q;
    ovld_d  = ovld_q && !out_ready_i;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (in_action_i) begin
            cmd_o.clr = 1'b1;
          end else begin
            cmd_o.ld_in = 1'b1;
            state_d = StProd;
          end
        end
      end
      StProd: begin
        cmd_o.prod = 1'b1;
        state_d = StTgt;
      end
      StTgt: begin
        cmd_o.tgt = 1'b1;
        state_d = StFmul;
      end
      StFmul: begin
        cmd_o.fmul = 1'b1;
        state_d = StFupd;
      end
      StFupd: begin
        cmd_o.fupd = 1'b1;
        state_d = StSat;
      end
      StSat: begin
        cmd_o.sat = 1'b1;
        state_d = StSq;
      end
      StSq: begin
        cmd_o.sq = 1'b1;
        state_d = StSum;
      end
      StSum: begin
        cmd_o.sum = 1'b1;
        state_d = StIter;
      end
      StIter: begin
        if (!sts_i.sqrt_busy && !sts_i.cordic_busy) begin
          state_d = StAmul;
        end
      end
      StAmul: begin
        cmd_o.amul = 1'b1;
        state_d = StArnd;
      end
      StArnd: begin
        cmd_o.arnd = 1'b1;
        state_d = StDone;
      end
      StDone: begin
        if (!ovld_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          ovld_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

endmodule

// ----- src/sliq_dp.sv -----
// Datapath of the lock-in detector: config registers, mixer, low-pass,
// saturation, bit-serial square root, CORDIC phase and output register.
// Depends on sliq_pkg; driven by sliq_ctrl.
`timescale 1ns / 1ps
module sliq_dp
  import sliq_pkg::*;
#(
  parameter int unsigned CordicSteps = CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [31:0]        cfg_data_i,
  input  logic signed [31:0] sample_i,
  input  logic signed [15:0] ref_sine_i,
  input  logic signed [15:0] ref_cosine_i,
  input  sliq_cmd_t          cmd_i,
  output sliq_sts_t          sts_o,
  output logic signed [31:0] in_phase_o,
  output logic signed [31:0] quadrature_out_o,
  output logic [31:0]        amplitude_o,
  output logic signed [18:0] phase_millideg_o,
  output logic [31:0]        sample_count_o,
  output logic               saturated_o,
  output logic               stable_o
);

  localparam logic [4:0] StepsLast = 5'(CordicSteps);

  function automatic logic signed [33:0] shr_sym(input logic signed [33:0] v,
                                                 input logic [4:0] sh);
    logic [33:0] mag;
    logic [33:0] q;
    mag = v[33] ? 34'(-v) : 34'(v);
    q = mag >> sh;
    return v[33] ? -$signed(q) : $signed(q);
  endfunction

  // configuration
  logic [15:0] gain_q;
  logic [31:0] min_amp_q, settle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= GainReset;
      min_amp_q <= '0;
      settle_q  <= SettleReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegFilterGain:   gain_q    <= cfg_data_i[15:0];
        RegMinAmplitude: min_amp_q <= cfg_data_i;
        RegSettlingCnt:  settle_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // mixer and low-pass
  logic signed [31:0] smp_q;
  logic signed [15:0] rs_q, rc_q;
  logic signed [47:0] pi_q, pq_q;
  logic signed [34:0] ti_q, tq_q, fi_q, fq_q;
  logic signed [52:0] mi_q, mq_q;
  logic [31:0]        cnt_q;
  logic [15:0]        gain_eff;
  logic signed [16:0] gain_s;
  logic signed [35:0] di, dq;
  logic [47:0]        mag_pi, mag_pq;
  logic [33:0]        rnd_pi, rnd_pq;
  logic [52:0]        mag_mi, mag_mq;
  logic [37:0]        rnd_mi, rnd_mq;
  logic signed [34:0] upd_i, upd_q;

  assign gain_eff = (gain_q > GainUnity) ? GainUnity : gain_q;
  assign gain_s   = $signed({1'b0, gain_eff});
  assign di = 36'(ti_q) - 36'(fi_q);
  assign dq = 36'(tq_q) - 36'(fq_q);
  assign mag_pi = pi_q[47] ? 48'(-pi_q) : 48'(pi_q);
  assign mag_pq = pq_q[47] ? 48'(-pq_q) : 48'(pq_q);
  assign rnd_pi = 34'((mag_pi + 48'd8192) >> 14);
  assign rnd_pq = 34'((mag_pq + 48'd8192) >> 14);
  assign mag_mi = mi_q[52] ? 53'(-mi_q) : 53'(mi_q);
  assign mag_mq = mq_q[52] ? 53'(-mq_q) : 53'(mq_q);
  assign rnd_mi = 38'((mag_mi + 53'd16384) >> 15);
  assign rnd_mq = 38'((mag_mq + 53'd16384) >> 15);
  assign upd_i = mi_q[52] ? -$signed(rnd_mi[34:0]) : $signed(rnd_mi[34:0]);
  assign upd_q = mq_q[52] ? -$signed(rnd_mq[34:0]) : $signed(rnd_mq[34:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      smp_q <= sample_i;
      rs_q  <= ref_sine_i;
      rc_q  <= ref_cosine_i;
    end
    if (cmd_i.prod) begin
      pi_q <= smp_q * rs_q;
      pq_q <= smp_q * rc_q;
    end
    if (cmd_i.tgt) begin
      ti_q <= pi_q[47] ? -$signed({1'b0, rnd_pi}) : $signed({1'b0, rnd_pi});
      tq_q <= pq_q[47] ? -$signed({1'b0, rnd_pq}) : $signed({1'b0, rnd_pq});
    end
    if (cmd_i.fmul) begin
      mi_q <= di * gain_s;
      mq_q <= dq * gain_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fi_q  <= '0;
      fq_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.clr) begin
      fi_q  <= '0;
      fq_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.fupd) begin
      fi_q <= fi_q + upd_i;
      fq_q <= fq_q + upd_q;
      if (cnt_q != '1) cnt_q <= cnt_q + 32'd1;
    end
  end

  // saturation and squares
  logic signed [31:0] iv_q, qv_q;
  logic               clip_q;
  logic               ci_hi, ci_lo, cq_hi, cq_lo;
  logic [31:0]        ai, aq;
  logic [63:0]        sqi_q, sqq_q;

  assign ci_hi = !fi_q[34] && (fi_q[33:31] != 3'b000);
  assign ci_lo =  fi_q[34] && (fi_q[33:31] != 3'b111);
  assign cq_hi = !fq_q[34] && (fq_q[33:31] != 3'b000);
  assign cq_lo =  fq_q[34] && (fq_q[33:31] != 3'b111);
  assign ai = iv_q[31] ? 32'(-iv_q) : 32'(iv_q);
  assign aq = qv_q[31] ? 32'(-qv_q) : 32'(qv_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sat) begin
      iv_q <= ci_hi ? 32'sh7FFFFFFF : ci_lo ? 32'sh80000000 : fi_q[31:0];
      qv_q <= cq_hi ? 32'sh7FFFFFFF : cq_lo ? 32'sh80000000 : fq_q[31:0];
      clip_q <= ci_hi | ci_lo | cq_hi | cq_lo;
    end
    if (cmd_i.sq) begin
      sqi_q <= ai * ai;
      sqq_q <= aq * aq;
    end
  end

  // square root, one result bit per cycle
  logic [63:0] rsrc_q;
  logic [34:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  rcnt_q;
  logic        rbusy_q;
  logic [34:0] rem_n;
  logic [34:0] trial;

  assign rem_n = {rem_q[32:0], rsrc_q[63:62]};
  assign trial = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      rsrc_q <= sqi_q + sqq_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (rbusy_q) begin
      rsrc_q <= {rsrc_q[61:0], 2'b00};
      if (rem_n >= trial) begin
        rem_q  <= rem_n - trial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= rem_n;
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rbusy_q <= 1'b0;
      rcnt_q  <= '0;
    end else if (cmd_i.sum) begin
      rbusy_q <= 1'b1;
      rcnt_q  <= '0;
    end else if (rbusy_q) begin
      rcnt_q <= rcnt_q + 5'd1;
      if (rcnt_q == 5'd31) rbusy_q <= 1'b0;
    end
  end

  // CORDIC vectoring: normalize one bit per cycle, then rotate
  logic signed [33:0] cx_q, cy_q, ang_q;
  logic [4:0]         k_q;
  logic               norm_q, rot_q, spc_q;
  logic [33:0]        ax, ay, mx;
  logic signed [33:0] xs, ys, atn;

  assign ax  = cx_q[33] ? 34'(-cx_q) : 34'(cx_q);
  assign ay  = cy_q[33] ? 34'(-cy_q) : 34'(cy_q);
  assign mx  = (ay > ax) ? ay : ax;
  assign xs  = shr_sym(cx_q, k_q);
  assign ys  = shr_sym(cy_q, k_q);
  assign atn = $signed({2'b00, AtanTable[k_q]});

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq) begin
      cx_q  <= 34'(iv_q);
      cy_q  <= 34'(qv_q);
      ang_q <= '0;
      k_q   <= '0;
      spc_q <= (iv_q == '0);
    end else if (norm_q) begin
      if (mx > 34'h40000000) begin
        cx_q <= shr_sym(cx_q, 5'd1);
        cy_q <= shr_sym(cy_q, 5'd1);
      end else if (mx < 34'h10000000) begin
        cx_q <= cx_q <<< 1;
        cy_q <= cy_q <<< 1;
      end else if (cx_q[33]) begin
        ang_q <= cy_q[33] ? -34'sh80000000 : 34'sh80000000;
        cx_q  <= -cx_q;
        cy_q  <= -cy_q;
      end
    end else if (rot_q && (cy_q != '0) && (k_q != StepsLast)) begin
      k_q <= k_q + 5'd1;
      if (!cy_q[33]) begin
        cx_q  <= cx_q + ys;
        cy_q  <= cy_q - xs;
        ang_q <= ang_q + atn;
      end else begin
        cx_q  <= cx_q - ys;
        cy_q  <= cy_q + xs;
        ang_q <= ang_q - atn;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_q <= 1'b0;
      rot_q  <= 1'b0;
    end else if (cmd_i.sq) begin
      norm_q <= (iv_q != '0);
      rot_q  <= 1'b0;
    end else if (norm_q) begin
      if (mx <= 34'h40000000 && mx >= 34'h10000000) begin
        norm_q <= 1'b0;
        rot_q  <= 1'b1;
      end
    end else if (rot_q && ((cy_q == '0) || (k_q == StepsLast))) begin
      rot_q <= 1'b0;
    end
  end

  assign sts_o.sqrt_busy   = rbusy_q;
  assign sts_o.cordic_busy = norm_q | rot_q;

  // final scaling, amplitude rounding, stability
  logic signed [53:0] pa_q;
  logic [31:0]        amp_q;
  logic signed [18:0] ph_q;
  logic               stab_q;
  logic [53:0]        mag_pa;
  logic [21:0]        rnd_pa;
  logic signed [18:0] ph_rot;

  assign mag_pa = pa_q[53] ? 54'(-pa_q) : 54'(pa_q);
  assign rnd_pa = 22'((mag_pa + 54'h80000000) >> 32);
  assign ph_rot = pa_q[53] ? -$signed(rnd_pa[18:0]) : $signed(rnd_pa[18:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.amul) begin
      pa_q  <= ang_q * PhaseFullMd;
      amp_q <= (rem_q > 35'(root_q)) ? root_q + 32'd1 : root_q;
    end
    if (cmd_i.arnd) begin
      if (spc_q) begin
        ph_q <= (qv_q == '0) ? '0 : qv_q[31] ? -PhaseQuarterMd : PhaseQuarterMd;
      end else begin
        ph_q <= ph_rot;
      end
      stab_q <= (cnt_q >= settle_q) && !clip_q && (amp_q >= min_amp_q);
    end
    if (cmd_i.out_ld) begin
      in_phase_o       <= iv_q;
      quadrature_out_o <= qv_q;
      amplitude_o      <= amp_q;
      phase_millideg_o <= ph_q;
      sample_count_o   <= cnt_q;
      saturated_o      <= clip_q;
      stable_o         <= stab_q;
    end
  end

endmodule

// ----- src/streaming_lockin_iq_detector.sv -----
// Top level of the streaming lock-in I/Q detector: stream and config ports,
// sliq_ctrl and sliq_dp. Depends on sliq_pkg.
`timescale 1ns / 1ps
// Mixes each sample with Q15 sine/cosine references, low-passes I and Q, and
// returns saturated I/Q, a rounded amplitude, a CORDIC phase in millidegrees,
// the sample count and saturated/stable flags. One item is in work at a time:
// the controller's step states plus a wait on the longer of the bit-serial square
// root and the CORDIC unit (normalize, then rotate; started in the squaring
// state, before the square root), and the finished result then waits for the
// previous one to be taken. A clear (tuser = 1) gives no result. A finished
// result waits in the output register while the next sample is taken. Config
// writes are accepted every cycle.
module streaming_lockin_iq_detector
  import sliq_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [63:0]  s_axis_tdata_i,  // sample[31:0], ref_sine, ref_cosine
  input  logic [0:0]   s_axis_tuser_i,  // action
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [151:0] m_axis_tdata_o,  // in_phase, quadrature_out, amplitude,
                                        // phase_millideg, sample_count, zeros
  output logic [1:0]   m_axis_tuser_o,  // saturated, stable
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_addr_i,
  input  logic [31:0]  cfg_data_i
);

  sliq_cmd_t cmd;
  sliq_sts_t sts;

  logic signed [31:0] in_phase, quadrature_out;
  logic [31:0]        amplitude, sample_count;
  logic signed [18:0] phase_millideg;
  logic               saturated, stable;

  assign cfg_ready_o = 1'b1;

  sliq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_action_i(s_axis_tuser_i[0]),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sliq_dp #(
    .CordicSteps(CORDIC_STEPS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .sample_i        (s_axis_tdata_i[31:0]),
    .ref_sine_i      (s_axis_tdata_i[47:32]),
    .ref_cosine_i    (s_axis_tdata_i[63:48]),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .in_phase_o      (in_phase),
    .quadrature_out_o(quadrature_out),
    .amplitude_o     (amplitude),
    .phase_millideg_o(phase_millideg),
    .sample_count_o  (sample_count),
    .saturated_o     (saturated),
    .stable_o        (stable)
  );

  assign m_axis_tdata_o = {5'd0, sample_count, phase_millideg, amplitude,
                           quadrature_out, in_phase};
  assign m_axis_tuser_o = {stable, saturated};

  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_ld |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("output register overwritten while a result waits");

  a_sqrt_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sum |-> !sts.sqrt_busy)
    else $error("square root restarted while busy");

  a_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.amul |-> (!sts.sqrt_busy && !sts.cordic_busy))
    else $error("result taken before iterative units finished");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($signed(m_axis_tdata_o[114:96]) <= 19'sd180000 &&
                         $signed(m_axis_tdata_o[114:96]) >= -19'sd180000))
    else $error("phase out of range");

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for streaming_lockin_iq_detector: stimulus table, then random
// samples and clears across register settings; each result is checked against a hand-worked
// table value or a built-in I/Q predictor. Depends on sliq_pkg and the detector RTL.
`timescale 1ns / 1ps
module tb;
  import sliq_pkg::*;

  typedef struct packed {
    logic signed [31:0] in_phase;
    logic signed [31:0] quad;
    logic [31:0]        amp;
    logic [18:0]        phase;
    logic [31:0]        count;
    logic               sat;
    logic               stable;
  } iq_res_t;

  typedef struct packed {
    logic               act;
    logic signed [31:0] smp;
    logic signed [15:0] sn;
    logic signed [15:0] cs;
    logic               known;
    iq_res_t            res;
  } stim_row_t;

  localparam int NumRows = 11;
  localparam longint HalfTurn = 64'sd1 <<< 31;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [63:0]  s_axis_tdata_i = '0;
  logic [0:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [151:0] m_axis_tdata_o;
  logic [1:0]   m_axis_tuser_o;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_addr_i = '0;
  logic [31:0]  cfg_data_i = '0;

  streaming_lockin_iq_detector DUT (.*);

  always #6 clk_i = ~clk_i;

  // predictor state and register copies
  longint      filt_i, filt_q;
  int unsigned sample_cnt;
  logic [15:0] gain_q15;
  logic [31:0] min_amp, settle_cnt;

  iq_res_t   expected_q[$];
  stim_row_t dir_rows[NumRows];
  int        mismatches = 0;
  int        burst_left = 0;
  bit        gaps_on = 1'b1;
  int        stall_mode = 0;
  int        stall_ctr = 0;

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  function automatic longint div_round(longint n, int sh);
    longint unsigned q;
    q = (mag(n) + (64'd1 << (sh - 1))) >> sh;
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint shr_sym(longint v, int sh);
    longint unsigned q;
    q = mag(v) >> sh;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clip32(longint v, inout bit clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic [31:0] root_round(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (v > r) r++;
    return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  function automatic logic [18:0] atan2_md(longint y, longint x);
    longint unsigned m;
    longint ang = 0;
    longint xs, ys, md;
    if (x == 0 && y == 0) return '0;
    if (x == 0) return (y > 0) ? 19'sd90000 : -19'sd90000;
    m = mag(x);
    if (mag(y) > m) m = mag(y);
    while (m > (64'd1 << 30)) begin
      x = shr_sym(x, 1);
      y = shr_sym(y, 1);
      m = m >> 1;
    end
    while (m != 0 && m < (64'd1 << 28)) begin
      x = x * 2;
      y = y * 2;
      m = m << 1;
    end
    if (x < 0) begin
      ang = (y >= 0) ? HalfTurn : -HalfTurn;
      x = -x;
      y = -y;
    end
    for (int k = 0; k < 31; k++) begin
      xs = shr_sym(x, k);
      ys = shr_sym(y, k);
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        ang = ang + longint'(AtanTable[k]);
      end else if (y < 0) begin
        x = x - ys;
        y = y + xs;
        ang = ang - longint'(AtanTable[k]);
      end else begin
        break;
      end
    end
    md = div_round(ang * 360000, 32);
    return md[18:0];
  endfunction

  // advances the detector state; returns 1 with the result for a sample, 0 for a clear
  function automatic bit lockin_step(input logic act, input logic signed [31:0] smp,
                                     input logic signed [15:0] sn,
                                     input logic signed [15:0] cs, output iq_res_t r);
    longint ti, tq, g, iv, qv;
    bit clipped = 1'b0;
    r = '0;
    if (act) begin
      filt_i = 0;
      filt_q = 0;
      sample_cnt = 0;
      return 1'b0;
    end
    ti = div_round(longint'(smp) * longint'(sn), 14);
    tq = div_round(longint'(smp) * longint'(cs), 14);
    g = (gain_q15 > GainUnity) ? longint'(GainUnity) : longint'(gain_q15);
    filt_i = filt_i + div_round((ti - filt_i) * g, 15);
    filt_q = filt_q + div_round((tq - filt_q) * g, 15);
    if (sample_cnt != 32'hFFFF_FFFF) sample_cnt++;
    iv = clip32(filt_i, clipped);
    qv = clip32(filt_q, clipped);
    r.in_phase = iv[31:0];
    r.quad = qv[31:0];
    r.amp = root_round(mag(iv) * mag(iv) + mag(qv) * mag(qv));
    r.phase = atan2_md(qv, iv);
    r.count = sample_cnt;
    r.sat = clipped;
    r.stable = (sample_cnt >= settle_cnt) && !clipped && (r.amp >= min_amp);
    return 1'b1;
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegFilterGain:   gain_q15 = val[15:0];
      RegMinAmplitude: min_amp = val;
      RegSettlingCnt:  settle_cnt = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain_wait();
    s_axis_tvalid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (90) @(posedge clk_i);
  endtask

  task automatic send_item(input logic act, input logic signed [31:0] smp,
                           input logic signed [15:0] sn, input logic signed [15:0] cs,
                           input bit known, input iq_res_t typed);
    iq_res_t r;
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {cs, sn, smp};
    s_axis_tuser_i <= act;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (lockin_step(act, smp, sn, cs, r)) expected_q.push_back(known ? typed : r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(10, 1);
      gap = gaps_on ? $urandom_range(6, 0) : 0;
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // result side: check on transfer, then pick the next ready value
  always @(posedge clk_i) begin
    iq_res_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.in_phase = m_axis_tdata_o[31:0];
      got.quad = m_axis_tdata_o[63:32];
      got.amp = m_axis_tdata_o[95:64];
      got.phase = m_axis_tdata_o[114:96];
      got.count = m_axis_tdata_o[146:115];
      got.sat = m_axis_tuser_o[0];
      got.stable = m_axis_tuser_o[1];
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got.in_phase !== want.in_phase || got.quad !== want.quad ||
            got.amp !== want.amp || got.phase !== want.phase ||
            got.count !== want.count || got.sat !== want.sat ||
            got.stable !== want.stable) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: exp %p got %p", want, got);
        end
      end
    end
    if (stall_ctr == 0) begin
      stall_mode = $urandom_range(2, 0);
      stall_ctr = $urandom_range(200, 20);
    end else begin
      stall_ctr--;
    end
    case (stall_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= 1'($urandom_range(1, 0));
      default: m_axis_tready_i <= ($urandom_range(3, 0) == 0);
    endcase
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [15:0] gains[6];
    logic [31:0] mins[4], settles[4];
    logic signed [31:0] smp;
    stim_row_t row;
    filt_i = 0;
    filt_q = 0;
    sample_cnt = 0;
    gain_q15 = GainReset;
    min_amp = '0;
    settle_cnt = SettleReset;
    gains = '{16'd1, 16'h8000, 16'd0, 16'hFFFF, 16'd1024, 16'd20000};
    mins = '{32'd0, 32'hFFFF_FFFF, 32'd5000, 32'd0};
    settles = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd20};

    // a clear, then full-gain rows with hand-worked results, then extremes and other rows
    dir_rows[0]  = '{1'b1, 32'sd0, 16'sd0, 16'sd0, 1'b0, '0};
    dir_rows[1]  = '{1'b0, 32'sd0, 16'sd0, 16'sd0, 1'b1,
                     '{32'sd0, 32'sd0, 32'd0, 19'd0, 32'd1, 1'b0, 1'b1}};
    dir_rows[2]  = '{1'b0, 32'sd16384, 16'sd16384, 16'sd0, 1'b1,
                     '{32'sd16384, 32'sd0, 32'd16384, 19'd0, 32'd2, 1'b0, 1'b1}};
    dir_rows[3]  = '{1'b0, 32'sd16384, 16'sd0, 16'sd16384, 1'b1,
                     '{32'sd0, 32'sd16384, 32'd16384, 19'sd90000, 32'd3, 1'b0, 1'b1}};
    dir_rows[4]  = '{1'b0, 32'sd16384, 16'sd0, -16'sd16384, 1'b1,
                     '{32'sd0, -32'sd16384, 32'd16384, -19'sd90000, 32'd4, 1'b0, 1'b1}};
    dir_rows[5]  = '{1'b0, 32'sd16384, -16'sd16384, 16'sd0, 1'b1,
                     '{-32'sd16384, 32'sd0, 32'd16384, 19'sd180000, 32'd5, 1'b0, 1'b1}};
    dir_rows[6]  = '{1'b0, 32'sh7FFF_FFFF, -16'sd32768, -16'sd32768, 1'b0, '0};
    dir_rows[7]  = '{1'b0, -32'sh8000_0000, -16'sd32768, 16'sd32767, 1'b0, '0};
    dir_rows[8]  = '{1'b0, -32'sh8000_0000, 16'sd32767, -16'sd32768, 1'b0, '0};
    dir_rows[9]  = '{1'b0, 32'sd12345, 16'sd23170, -16'sd23170, 1'b0, '0};
    dir_rows[10] = '{1'b0, -32'sd777, 16'sd1, 16'sd32767, 1'b0, '0};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first row runs at the reset gain, before the full-gain rows
    send_item(1'b0, 32'sd1000000, 16'sd3000, -16'sd3000, 1'b0, '0);
    drain_wait();
    cfg_write(RegFilterGain, 32'h8000);
    for (int i = 0; i < NumRows; i++) begin
      row = dir_rows[i];
      send_item(row.act, row.smp, row.sn, row.cs, row.known, row.res);
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain_wait();
      cfg_write(RegFilterGain, (ph < 6) ? gains[ph] : $urandom_range(32768, 1));
      cfg_write(RegMinAmplitude, (ph < 4) ? mins[ph] : $urandom_range(100000, 0));
      cfg_write(RegSettlingCnt, (ph < 4) ? settles[ph] : $urandom_range(60, 1));
      gaps_on = (ph != 3);
      if (ph[0]) send_item(1'b1, $urandom, 16'($urandom), 16'($urandom), 1'b0, '0);
      for (int n = 0; n < 50; n++) begin
        case ($urandom_range(3, 0))
          0: smp = $urandom;
          1: smp = $signed($urandom_range(65535, 0)) - 32768;
          default: smp = $signed($urandom) >>> $urandom_range(30, 4);
        endcase
        send_item(($urandom_range(19, 0) == 0), smp, 16'($urandom), 16'($urandom),
                  1'b0, '0);
      end
    end

    drain_wait();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
src/sliq_pkg.sv
src/sliq_ctrl.sv
src/sliq_dp.sv
src/streaming_lockin_iq_detector.sv
bench/tb.sv
